FILE: rtl/hbv_pkg.sv
`default_nettype none
package hbv_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_W    = 32;
  localparam int CONC_W    = FRAC_BITS + 1;
  localparam int IDX_W     = 20;
  localparam int EPS_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam int ROOT_W    = (WORD_W + FRAC_BITS + 1) / 2;
  localparam int X_W       = ROOT_W + 1;
  localparam int POS_W     = $clog2(X_W);
  localparam int MANT_BITS = 30;
  localparam int MANT_W    = MANT_BITS + 1;
  localparam int LG_W      = FRAC_BITS + POS_W + 1;
  localparam int E_W       = IDX_W + 1;
  localparam int T_W       = E_W + LG_W - FRAC_BITS;
  localparam int K_W       = T_W - FRAC_BITS;
  localparam int DIV_W     = WORD_W + FRAC_BITS;

  localparam int LATENCY   = ROOT_W + DIV_W + 3;
  localparam int BN_DLY    = ROOT_W - 1;
  localparam int PARAM_DLY = ROOT_W + FRAC_BITS;
  localparam int T1_DLY    = DIV_W - 2 * FRAC_BITS - 4;

  localparam logic [CONC_W-1:0] CONC_ONE = CONC_W'(1) << FRAC_BITS;
  localparam logic [WORD_W-1:0] WORD_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BINGHAM_ONE = 3'd0,
    CFG_BINGHAM_TWO = 3'd1,
    CFG_INDEX_ONE   = 3'd2,
    CFG_INDEX_TWO   = 3'd3,
    CFG_CONSIST     = 3'd4,
    CFG_EPS         = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [WORD_W-1:0] term;
    logic              ovf;
  } pow_t;

  // The n-th factor 2^(2^-n) in Q1.30, by repeated floored square roots.
  function automatic logic [63:0] exp_root(input int n);
    logic [63:0] r;
    logic [63:0] v;
    logic [63:0] b;
    logic [63:0] res;
    r = 64'd1 << (MANT_BITS + 1);
    for (int j = 1; j <= n; j++) begin
      v   = r << MANT_BITS;
      res = '0;
      b   = 64'd1 << 62;
      for (int k = 0; k < 32; k++) begin
        if (v >= res + b) begin
          v   = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      r = res;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/hbv_in_if.sv
`default_nettype none
interface hbv_in_if import hbv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CONC_W-1:0] concentration;
  logic [WORD_W-1:0] strain_rate_sq;

  modport source(output valid, output concentration, output strain_rate_sq, input ready);
  modport sink(input valid, input concentration, input strain_rate_sq, output ready);
endinterface
`default_nettype wire

FILE: rtl/hbv_out_if.sv
`default_nettype none
interface hbv_out_if import hbv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] viscosity;
  logic              saturated;

  modport source(output valid, output viscosity, output saturated, input ready);
  modport sink(input valid, input viscosity, input saturated, output ready);
endinterface
`default_nettype wire

FILE: rtl/hbv_delay.sv
`default_nettype none
module hbv_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] line [D];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int i = 1; i < D; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign q = line[D-1];

endmodule
`default_nettype wire

FILE: rtl/hbv_sqrt.sv
`default_nettype none
module hbv_sqrt import hbv_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [WORD_W-1:0] s,
  output logic [ROOT_W-1:0] root
);

  localparam int V_W = 2 * ROOT_W;

  logic [V_W-1:0]    rad [ROOT_W];
  logic [ROOT_W:0]   rem [ROOT_W];
  logic [ROOT_W-1:0] rt  [ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    logic [V_W-1:0]    rad_i;
    logic [ROOT_W:0]   rem_i;
    logic [ROOT_W-1:0] rt_i;
    logic [ROOT_W+2:0] cur;
    logic [ROOT_W+2:0] trial;
    logic [ROOT_W+2:0] diff;
    logic              ge;

    if (j == 0) begin : g_first
      assign rad_i = V_W'({s, {FRAC_BITS{1'b0}}});
      assign rem_i = '0;
      assign rt_i  = '0;
    end else begin : g_next
      assign rad_i = rad[j-1];
      assign rem_i = rem[j-1];
      assign rt_i  = rt[j-1];
    end

    assign cur   = {rem_i, rad_i[V_W-1 -: 2]};
    assign trial = {1'b0, rt_i, 2'b01};
    assign ge    = cur >= trial;
    assign diff  = cur - trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rad[j] <= rad_i << 2;
        rem[j] <= ge ? diff[ROOT_W:0] : cur[ROOT_W:0];
        rt[j]  <= {rt_i[ROOT_W-2:0], ge};
      end
    end
  end

  assign root = rt[ROOT_W-1];

endmodule
`default_nettype wire

FILE: rtl/hbv_log2.sv
`default_nettype none
module hbv_log2 import hbv_pkg::*; (
  input  logic                   clk,
  input  logic                   en,
  input  logic [X_W-1:0]         x,
  output logic signed [LG_W-1:0] lg
);

  localparam int SH_W = $clog2(MANT_BITS + 1);

  logic [MANT_W-1:0]    m  [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] fr [FRAC_BITS+1];
  logic [POS_W-1:0]     pp [FRAC_BITS+1];

  logic [POS_W-1:0]         p_c;
  logic [SH_W-1:0]          sh_c;
  logic [MANT_W+X_W-1:0]    wide_c;
  logic signed [POS_W:0]    ip;

  always_comb begin
    p_c = '0;
    for (int i = 0; i < X_W; i++) begin
      if (x[i]) begin
        p_c = POS_W'(i);
      end
    end
    sh_c   = SH_W'(MANT_BITS) - SH_W'(p_c);
    wide_c = {{MANT_W{1'b0}}, x} << sh_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m[0]  <= wide_c[MANT_W-1:0];
      fr[0] <= '0;
      pp[0] <= p_c;
    end
  end

  for (genvar j = 0; j < FRAC_BITS; j++) begin : g_stage
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     t;

    assign sq = m[j] * m[j];
    assign t  = sq[MANT_BITS +: MANT_W+1];

    always_ff @(posedge clk) begin
      if (en) begin
        m[j+1]  <= t[MANT_W] ? t[MANT_W:1] : t[MANT_W-1:0];
        fr[j+1] <= {fr[j][FRAC_BITS-2:0], t[MANT_W]};
        pp[j+1] <= pp[j];
      end
    end
  end

  assign ip = $signed({1'b0, pp[FRAC_BITS]}) - $signed((POS_W+1)'(FRAC_BITS));
  assign lg = {ip, fr[FRAC_BITS]};

endmodule
`default_nettype wire

FILE: rtl/hbv_exp2.sv
`default_nettype none
module hbv_exp2 import hbv_pkg::*; (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [E_W-1:0]  e,
  input  logic signed [LG_W-1:0] lg,
  input  logic [WORD_W-1:0]      kap,
  output pow_t                   pw
);

  logic signed [E_W+LG_W-1:0] prod_c;
  logic [T_W-1:0]             t_c;

  logic [MANT_W-1:0]    acc [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] f   [FRAC_BITS+1];
  logic [K_W-1:0]       k   [FRAC_BITS+1];

  logic [WORD_W-1:0]        kap_d;
  logic [WORD_W+MANT_W-1:0] kp_c;
  logic [WORD_W:0]          mk;
  logic signed [K_W-1:0]    kk;
  pow_t                     pw_c;

  assign prod_c = e * lg;
  assign t_c    = prod_c[E_W+LG_W-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      acc[0] <= MANT_W'(1) << MANT_BITS;
      f[0]   <= t_c[FRAC_BITS-1:0];
      k[0]   <= t_c[T_W-1:FRAC_BITS];
    end
  end

  for (genvar j = 0; j < FRAC_BITS; j++) begin : g_stage
    localparam logic [MANT_W-1:0] ROOT = MANT_W'(exp_root(j + 1));
    logic [2*MANT_W-1:0] pr;

    assign pr = acc[j] * ROOT;

    always_ff @(posedge clk) begin
      if (en) begin
        acc[j+1] <= f[j][FRAC_BITS-1-j] ? pr[MANT_BITS +: MANT_W] : acc[j];
        f[j+1]   <= f[j];
        k[j+1]   <= k[j];
      end
    end
  end

  hbv_delay #(.W(WORD_W), .D(FRAC_BITS + 1)) u_kap_dly (
    .clk(clk), .en(en), .d(kap), .q(kap_d)
  );

  assign kp_c = kap_d * acc[FRAC_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      mk <= kp_c[MANT_BITS +: WORD_W+1];
      kk <= $signed(k[FRAC_BITS]);
    end
  end

  always_comb begin
    logic [K_W-1:0] nk;
    nk       = K_W'(-kk);
    pw_c.ovf  = 1'b0;
    pw_c.term = '0;
    if (mk == '0) begin
      pw_c.term = '0;
    end else if (!kk[K_W-1]) begin
      if (($unsigned(kk) >= K_W'(WORD_W + 1)) ||
          (mk > {1'b0, WORD_MAX >> $unsigned(kk)})) begin
        pw_c.ovf  = 1'b1;
        pw_c.term = WORD_MAX;
      end else begin
        pw_c.term = WORD_W'(mk << $unsigned(kk));
      end
    end else if (nk >= K_W'(WORD_W + 1)) begin
      pw_c.term = '0;
    end else begin
      pw_c.term = WORD_W'(mk >> nk);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pw <= pw_c;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/hbv_div.sv
`default_nettype none
module hbv_div import hbv_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [WORD_W-1:0] num,
  input  logic [X_W-1:0]    den,
  output logic [DIV_W-1:0]  quo
);

  logic [DIV_W-1:0] nn [DIV_W];
  logic [X_W-1:0]   rm [DIV_W];
  logic [DIV_W-1:0] qq [DIV_W];
  logic [X_W-1:0]   dd [DIV_W];

  for (genvar j = 0; j < DIV_W; j++) begin : g_stage
    logic [DIV_W-1:0] nn_i;
    logic [X_W-1:0]   rm_i;
    logic [DIV_W-1:0] qq_i;
    logic [X_W-1:0]   dd_i;
    logic [X_W:0]     cur;
    logic [X_W:0]     diff;
    logic             ge;

    if (j == 0) begin : g_first
      assign nn_i = {num, {FRAC_BITS{1'b0}}};
      assign rm_i = '0;
      assign qq_i = '0;
      assign dd_i = den;
    end else begin : g_next
      assign nn_i = nn[j-1];
      assign rm_i = rm[j-1];
      assign qq_i = qq[j-1];
      assign dd_i = dd[j-1];
    end

    assign cur  = {rm_i, nn_i[DIV_W-1]};
    assign ge   = cur >= {1'b0, dd_i};
    assign diff = cur - {1'b0, dd_i};

    always_ff @(posedge clk) begin
      if (en) begin
        nn[j] <= nn_i << 1;
        rm[j] <= ge ? diff[X_W-1:0] : cur[X_W-1:0];
        qq[j] <= {qq_i[DIV_W-2:0], ge};
        dd[j] <= dd_i;
      end
    end
  end

  assign quo = qq[DIV_W-1];

endmodule
`default_nettype wire

FILE: rtl/two_phase_hb_viscosity_core.sv
// Two-phase regularised Herschel-Bulkley viscosity, Q16.16 fixed point.
// Input beats on feed carry a concentration and a squared shear measure;
// each gives exactly one result beat on the result channel, in order,
// holding the viscosity and a flag that is set when it saturated.
// The block is a fixed pipeline of 75 register stages; a new beat can be
// taken in every cycle while the receiver does not stall. The depth is
// set by the 24-step square root and the 48-step restoring divider that
// forms the yield term.
// When the receiver stalls with a result waiting, the whole pipeline
// holds and feed.ready falls; empty stages are not compressed, and the
// pipeline resumes without losing or repeating a beat.
// The six parameter registers are written through cfg_we, cfg_index and
// cfg_data, one per cycle; the user must write them only while no beat is
// in flight (not enforced); a write to an index beyond the list is ignored.
// Reset is synchronous: it empties the pipeline and restores the
// default parameters (both Bingham numbers 1.0, both indices 2.0,
// consistency ratio 2.0, zero regulariser).
`default_nettype none
module two_phase_hb_viscosity_core import hbv_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  hbv_in_if.sink               feed,
  hbv_out_if.source            result
);

  logic [WORD_W-1:0] bingham_one;
  logic [WORD_W-1:0] bingham_two;
  logic [IDX_W-1:0]  index_one;
  logic [IDX_W-1:0]  index_two;
  logic [WORD_W-1:0] consist;
  logic [EPS_W-1:0]  eps;

  always_ff @(posedge clk) begin
    if (rst) begin
      bingham_one <= WORD_W'(65536);
      bingham_two <= WORD_W'(65536);
      index_one   <= IDX_W'(131072);
      index_two   <= IDX_W'(131072);
      consist     <= WORD_W'(131072);
      eps         <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BINGHAM_ONE: bingham_one <= cfg_data;
        CFG_BINGHAM_TWO: bingham_two <= cfg_data;
        CFG_INDEX_ONE:   index_one   <= cfg_data[IDX_W-1:0];
        CFG_INDEX_TWO:   index_two   <= cfg_data[IDX_W-1:0];
        CFG_CONSIST:     consist     <= cfg_data;
        CFG_EPS:         eps         <= cfg_data[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  logic               en;
  logic [LATENCY-1:0] vld;

  assign en         = !vld[LATENCY-1] || result.ready;
  assign feed.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LATENCY-2:0], feed.valid};
    end
  end

  logic [CONC_W-1:0] c0;
  logic [WORD_W-1:0] s0;

  always_ff @(posedge clk) begin
    if (en) begin
      c0 <= (feed.concentration > CONC_ONE) ? CONC_ONE : feed.concentration;
      s0 <= feed.strain_rate_sq;
    end
  end

  logic [CONC_W-1:0]        cb0;
  logic [CONC_W+WORD_W-1:0] pb1;
  logic [CONC_W+WORD_W-1:0] pb2;
  logic [CONC_W+WORD_W-1:0] pk1;
  logic [CONC_W+WORD_W-1:0] pk2;
  logic [CONC_W+IDX_W-1:0]  pn1;
  logic [CONC_W+IDX_W-1:0]  pn2;

  assign cb0 = CONC_ONE - c0;

  always_ff @(posedge clk) begin
    if (en) begin
      pb1 <= c0 * bingham_one;
      pb2 <= cb0 * bingham_two;
      pk1 <= (CONC_W+WORD_W)'(c0) << FRAC_BITS;
      pk2 <= cb0 * consist;
      pn1 <= c0 * index_one;
      pn2 <= cb0 * index_two;
    end
  end

  logic [CONC_W+WORD_W:0] bsum;
  logic [CONC_W+WORD_W:0] ksum;
  logic [CONC_W+IDX_W:0]  nsum;
  logic [IDX_W-1:0]       n_c;
  logic [WORD_W-1:0]      bn;
  logic [WORD_W-1:0]      kap;
  logic signed [E_W-1:0]  ex;

  assign bsum = pb1 + pb2;
  assign ksum = pk1 + pk2;
  assign nsum = pn1 + pn2;
  assign n_c  = nsum[FRAC_BITS +: IDX_W];

  always_ff @(posedge clk) begin
    if (en) begin
      bn  <= bsum[FRAC_BITS +: WORD_W];
      kap <= ksum[FRAC_BITS +: WORD_W];
      ex  <= $signed({1'b0, n_c}) - $signed(E_W'(CONC_ONE));
    end
  end

  logic [ROOT_W-1:0] root;

  hbv_sqrt u_sqrt (.clk(clk), .en(en), .s(s0), .root(root));

  logic [X_W-1:0] x;

  always_ff @(posedge clk) begin
    if (en) begin
      x <= X_W'(root) + X_W'(eps);
    end
  end

  logic [WORD_W-1:0] bn_d;

  hbv_delay #(.W(WORD_W), .D(BN_DLY)) u_bn_dly (
    .clk(clk), .en(en), .d(bn), .q(bn_d)
  );

  logic signed [LG_W-1:0] lg;

  hbv_log2 u_log2 (.clk(clk), .en(en), .x(x), .lg(lg));

  logic [E_W+WORD_W-1:0] par_d;

  hbv_delay #(.W(E_W + WORD_W), .D(PARAM_DLY)) u_par_dly (
    .clk(clk), .en(en), .d({ex, kap}), .q(par_d)
  );

  pow_t pw;
  pow_t pw_d;

  hbv_exp2 u_exp2 (
    .clk(clk), .en(en),
    .e($signed(par_d[E_W+WORD_W-1:WORD_W])), .lg(lg), .kap(par_d[WORD_W-1:0]),
    .pw(pw)
  );

  hbv_delay #(.W($bits(pow_t)), .D(T1_DLY)) u_pw_dly (
    .clk(clk), .en(en), .d(pw), .q(pw_d)
  );

  logic [DIV_W-1:0] quo;

  hbv_div u_div (.clk(clk), .en(en), .num(bn_d), .den(x), .quo(quo));

  logic xz_d;

  hbv_delay #(.W(1), .D(DIV_W)) u_xz_dly (
    .clk(clk), .en(en), .d(x == '0), .q(xz_d)
  );

  logic [DIV_W:0]    sum;
  logic              sat_c;
  logic [WORD_W-1:0] visc;
  logic              sat;

  assign sum   = (DIV_W+1)'(pw_d.term) + (DIV_W+1)'(quo);
  assign sat_c = xz_d || pw_d.ovf || (sum > (DIV_W+1)'(WORD_MAX));

  always_ff @(posedge clk) begin
    if (en) begin
      visc <= sat_c ? WORD_MAX : sum[WORD_W-1:0];
      sat  <= sat_c;
    end
  end

  assign result.valid     = vld[LATENCY-1];
  assign result.viscosity = visc;
  assign result.saturated = sat;

`ifndef SYNTHESIS
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline valid bits moved during a stall");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    feed.valid && feed.ready |=> vld[0])
    else $error("accepted beat did not enter the first stage");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.saturated |-> result.viscosity == WORD_MAX)
    else $error("saturated result without the maximum value");

  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |-> !feed.ready)
    else $error("input taken while the output stage is blocked");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_two_phase_hb_viscosity_core.sv
`default_nettype none
module tb_two_phase_hb_viscosity_core;
  import hbv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam int BATCHES    = 9;
  localparam int BATCH_LEN  = 180;
  localparam int HOLD_LEN   = 400;
  localparam int DRAIN_WAIT = LATENCY + 10;

  typedef struct {
    logic [WORD_W-1:0] visc;
    logic              sat;
  } visc_t;

  typedef struct {
    logic [CONC_W-1:0] conc;
    logic [WORD_W-1:0] shear;
    bit                fixed;
    logic [WORD_W-1:0] visc;
    logic              sat;
  } row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0] cfg_data;

  hbv_in_if  feed_if ();
  hbv_out_if res_if ();

  two_phase_hb_viscosity_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .feed      (feed_if),
    .result    (res_if)
  );

  logic [31:0] bn_one, bn_two, kr;
  logic [19:0] nx_one, nx_two;
  logic [15:0] eps;

  visc_t visc_q[$];
  int errors = 0;
  int results_seen = 0;
  int saturated_seen = 0;
  int send_idle = 36;
  int recv_idle = 87;
  bit stall_req = 0;

  function automatic logic [63:0] sqrt_floor(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint log2_q(input logic [63:0] x);
    int p;
    logic [63:0] m;
    logic [63:0] frac;
    p = 0;
    frac = '0;
    while (p < 63 && (x >> (p + 1)) != 0) p++;
    if (p >= MANT_BITS) m = x >> (p - MANT_BITS);
    else m = x << (MANT_BITS - p);
    for (int i = 0; i < FRAC_BITS; i++) begin
      m = (m * m) >> MANT_BITS;
      frac = frac << 1;
      if (m >= (64'd2 << MANT_BITS)) begin
        m = m >> 1;
        frac = frac | 64'd1;
      end
    end
    return longint'(p - FRAC_BITS) * (longint'(1) << FRAC_BITS) + longint'(frac);
  endfunction

  function automatic longint floor_frac(input longint v);
    if (v >= 0) return v >>> FRAC_BITS;
    return -((-v + (longint'(1) << FRAC_BITS) - 1) >>> FRAC_BITS);
  endfunction

  function automatic logic [63:0] power_term(input logic [63:0] kap, input longint t,
                                             output bit ovf);
    longint k;
    logic [63:0] f;
    logic [63:0] acc;
    logic [63:0] r;
    logic [63:0] m;
    ovf = 0;
    k = floor_frac(t);
    f = 64'(t - k * (longint'(1) << FRAC_BITS));
    acc = 64'd1 << MANT_BITS;
    r = 64'd2 << MANT_BITS;
    for (int i = 1; i <= FRAC_BITS; i++) begin
      r = sqrt_floor(r << MANT_BITS);
      if ((f >> (FRAC_BITS - i)) & 64'd1) acc = (acc * r) >> MANT_BITS;
    end
    m = (kap * acc) >> MANT_BITS;
    if (m == 0) return 0;
    if (k >= 0) begin
      if (k >= 33 || m > (64'hFFFF_FFFF >> k)) begin
        ovf = 1;
        return 64'hFFFF_FFFF;
      end
      return m << k;
    end
    if (-k >= 64) return 0;
    return m >> (-k);
  endfunction

  function automatic visc_t viscosity_of(input logic [CONC_W-1:0] conc,
                                         input logic [WORD_W-1:0] shear);
    logic [63:0] c, cb, x, bn, kap, n, t1, t2, sum;
    longint e;
    bit ovf;
    visc_t res;
    c = 64'(conc);
    if (c > 64'(CONC_ONE)) c = 64'(CONC_ONE);
    cb = 64'(CONC_ONE) - c;
    x = sqrt_floor(64'(shear) << FRAC_BITS) + 64'(eps);
    if (x == 0) begin
      res.visc = WORD_MAX;
      res.sat = 1'b1;
      return res;
    end
    bn  = (c * 64'(bn_one) + cb * 64'(bn_two)) >> FRAC_BITS;
    kap = (c * 64'(CONC_ONE) + cb * 64'(kr)) >> FRAC_BITS;
    n   = (c * 64'(nx_one) + cb * 64'(nx_two)) >> FRAC_BITS;
    e = longint'(n) - longint'(CONC_ONE);
    t1 = power_term(kap, floor_frac(e * log2_q(x)), ovf);
    t2 = (bn << FRAC_BITS) / x;
    sum = t1 + t2;
    if (ovf || sum > 64'hFFFF_FFFF) begin
      res.visc = WORD_MAX;
      res.sat = 1'b1;
    end else begin
      res.visc = sum[31:0];
      res.sat = 1'b0;
    end
    return res;
  endfunction

  function automatic void store_param(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [WORD_W-1:0] val);
    case (idx)
      CFG_BINGHAM_ONE: bn_one = val;
      CFG_BINGHAM_TWO: bn_two = val;
      CFG_INDEX_ONE:   nx_one = val[19:0];
      CFG_INDEX_TWO:   nx_two = val[19:0];
      CFG_CONSIST:     kr = val;
      CFG_EPS:         eps = val[15:0];
      default: ;
    endcase
  endfunction

  task automatic write_param(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    store_param(idx, val);
  endtask

  task automatic write_all(input logic [31:0] b1, input logic [31:0] b2, input logic [31:0] n1,
                           input logic [31:0] n2, input logic [31:0] k,
                           input logic [31:0] ep);
    wait (visc_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    write_param(CFG_BINGHAM_ONE, b1);
    write_param(CFG_BINGHAM_TWO, b2);
    write_param(CFG_INDEX_ONE, n1);
    write_param(CFG_INDEX_TWO, n2);
    write_param(CFG_CONSIST, k);
    write_param(CFG_EPS, ep);
    write_param($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, $urandom);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_beat(input logic [CONC_W-1:0] conc, input logic [WORD_W-1:0] shear,
                           input bit fixed, input visc_t fixed_res);
    while ($urandom_range(99) < send_idle) begin
      feed_if.valid <= 1'b0;
      @(posedge clk);
    end
    feed_if.valid <= 1'b1;
    feed_if.concentration <= conc;
    feed_if.strain_rate_sq <= shear;
    do @(posedge clk); while (!feed_if.ready);
    if (fixed) visc_q.push_back(fixed_res);
    else visc_q.push_back(viscosity_of(conc, shear));
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Timed out with %0d results outstanding", visc_q.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    visc_t got;
    visc_t want;
    int hold;
    hold = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_if.valid && res_if.ready) begin
        got.visc = res_if.viscosity;
        got.sat = res_if.saturated;
        results_seen++;
        if (got.sat === 1'b1) saturated_seen++;
        if (visc_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Unexpected result beat: visc %h sat %b", got.visc, got.sat);
        end else begin
          want = visc_q.pop_front();
          if (got.visc !== want.visc || got.sat !== want.sat) begin
            errors++;
            if (errors <= 10)
              $display("Mismatch at beat %0d: expected visc %h sat %b, got visc %h sat %b",
                       results_seen, want.visc, want.sat, got.visc, got.sat);
          end
        end
      end
      if (stall_req) begin
        stall_req = 0;
        hold = HOLD_LEN;
      end
      if (hold > 0) begin
        hold--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  initial begin
    row_t rows[14];
    visc_t fr;
    logic [CONC_W-1:0] c;
    logic [WORD_W-1:0] s;
    int sel;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    feed_if.valid = 1'b0;
    feed_if.concentration = '0;
    feed_if.strain_rate_sq = '0;
    bn_one = 32'h0001_0000;
    bn_two = 32'h0001_0000;
    nx_one = 20'h2_0000;
    nx_two = 20'h2_0000;
    kr = 32'h0002_0000;
    eps = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rows[0]  = '{17'd0,      32'd0,          1, WORD_MAX, 1'b1};
    rows[1]  = '{17'd65536,  32'd0,          1, WORD_MAX, 1'b1};
    rows[2]  = '{17'd131071, 32'd0,          1, WORD_MAX, 1'b1};
    rows[3]  = '{17'd0,      32'd1,          0, '0, 1'b0};
    rows[4]  = '{17'd65536,  32'h0001_0000,  0, '0, 1'b0};
    rows[5]  = '{17'd32768,  32'h0001_0000,  0, '0, 1'b0};
    rows[6]  = '{17'd131071, 32'hFFFF_FFFF,  0, '0, 1'b0};
    rows[7]  = '{17'd0,      32'hFFFF_FFFF,  0, '0, 1'b0};
    rows[8]  = '{17'd65536,  32'hFFFF_FFFF,  0, '0, 1'b0};
    rows[9]  = '{17'd1,      32'd2,          0, '0, 1'b0};
    rows[10] = '{17'd65535,  32'h0123_4567,  0, '0, 1'b0};
    rows[11] = '{17'd100000, 32'h0001_0000,  0, '0, 1'b0};
    rows[12] = '{17'd0,      32'h8000_0000,  0, '0, 1'b0};
    rows[13] = '{17'd43690,  32'h5555_AAAA,  0, '0, 1'b0};
    foreach (rows[i]) begin
      fr.visc = rows[i].visc;
      fr.sat = rows[i].sat;
      send_beat(rows[i].conc, rows[i].shear, rows[i].fixed, fr);
    end
    feed_if.valid <= 1'b0;
    @(posedge clk);

    for (int b = 0; b < BATCHES; b++) begin
      send_idle = (b < 3) ? 36 : (b < 6) ? 87 : 0;
      recv_idle = (b < 3) ? 87 : (b < 6) ? 36 : 0;
      case (b)
        0: ;
        1: write_all(0, 0, 0, 0, 0, 0);
        2: write_all('1, '1, '1, '1, '1, '1);
        3: write_all($urandom, $urandom, 32'h8000, 32'h4000, $urandom >> 8, $urandom_range(7));
        default: write_all($urandom >> $urandom_range(16), $urandom >> $urandom_range(16),
                           $urandom_range(32'h3_0000), $urandom_range(32'h3_0000),
                           $urandom >> $urandom_range(20),
                           ($urandom_range(2) == 0) ? 32'd0 : $urandom);
      endcase
      for (int i = 0; i < BATCH_LEN; i++) begin
        if (b == 4 && i == 50) stall_req = 1;
        if (b == 5 && i == 60) begin
          feed_if.valid <= 1'b0;
          wait (visc_q.size() == 0);
          @(posedge clk);
        end
        sel = $urandom_range(9);
        c = (sel == 0) ? 17'd0 : (sel == 1) ? CONC_ONE :
            (sel == 2) ? 17'($urandom_range(131071, 65537)) : 17'($urandom_range(65536));
        sel = $urandom_range(9);
        s = (sel == 0) ? 32'd0 : (sel < 3) ? 32'($urandom_range(255)) :
            (sel == 3) ? 32'hFFFF_FFFF : $urandom >> $urandom_range(24);
        send_beat(c, s, 0, fr);
      end
      feed_if.valid <= 1'b0;
    end

    wait (visc_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (visc_q.size() != 0) errors++;
    $display("Checked %0d viscosity beats (%0d saturated) over %0d parameter sets,",
             results_seen, saturated_seen, BATCHES);
    $display("with sender and receiver idling in turn and one long result stall.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", errors);
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
